/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/dcp_pkg.sv */
`default_nettype none
package dcp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W    = 32;
    localparam int W_W      = 24;
    localparam int REST_W   = 31;
    localparam int STIFF_W  = 17;
    localparam int MAG_W    = 33;
    localparam int SQ_W     = 66;
    localparam int ROOT_W   = 33;
    localparam int KP_W     = 41;
    localparam int WSUM_W   = 25;
    localparam int K_W      = 18;
    localparam int S_DATA_W = 272;
    localparam int M_DATA_W = 192;
    localparam logic [STIFF_W-1:0] STIFF_RESET = 17'h10000;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [2:0]            sgn;
        logic [2:0][MAG_W-1:0] mag;
        logic [W_W-1:0]        wa;
        logic [W_W-1:0]        wb;
        logic [REST_W-1:0]     rest;
    } front_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [2:0]            sgn;
        logic [2:0][MAG_W-1:0] mag;
        logic [REST_W-1:0]     rest;
        logic [KP_W-1:0]       pka;
        logic [KP_W-1:0]       pkb;
        logic [WSUM_W-1:0]     wsum;
        logic                  skip;
    } root_side_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [2:0]            sgn;
        logic                  dneg;
        logic [ROOT_W-1:0]     dmag;
        logic                  skip;
    } div_side_t;
endpackage
`default_nettype wire

/* design/distance_constraint_projection.sv */
`default_nettype none
// Projects one distance constraint between two particles per transfer. The block
// takes a new item every cycle unless the pipeline is stalled and returns results
// in order, after the 33-step square root and the one-bit-per-stage dividers. A
// result that waits on the output only stops the pipeline once its last stage
// holds an item as well. Stiffness is written on the cfg channel and is sampled
// as items move from stage 1 into stage 2, so it should be changed only while no
// item is in flight.
`include "assert_macros.svh"
module distance_constraint_projection #(
    parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_x, first_y, first_z, first_weight, second_x, second_y, second_z,
    // second_weight, rest_length, zero pad
    input  logic [dcp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_first_x, new_first_y, new_first_z, new_second_x, new_second_y, new_second_z
    output logic [dcp_pkg::M_DATA_W-1:0]   m_tdata,
    // skipped
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dcp_pkg::STIFF_W-1:0]    cfg_data
);
    import dcp_pkg::*;

    localparam int DIR_W = FRAC_BITS + 1;
    localparam int QW    = (K_W > DIR_W) ? K_W : DIR_W;
    localparam int ND_W  = (KP_W > MAG_W + FRAC_BITS) ? KP_W : MAG_W + FRAC_BITS;
    localparam int DV_W  = ROOT_W;
    localparam int TP_W  = ROOT_W + K_W;
    localparam int TA_W  = TP_W - FRAC_BITS;
    localparam int MP_W  = DIR_W + TA_W;
    localparam int MV_W  = MP_W - FRAC_BITS;
    localparam int SUM_W = ((MV_W > POS_W) ? MV_W : POS_W) + 2;
    localparam int LANES = 5;
    localparam logic [QW-1:0] K_MAX   = QW'((1 << STIFF_W) - 1);
    localparam logic [QW-1:0] DIR_MAX = QW'(1) << FRAC_BITS;

    function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic [SUM_W-POS_W:0] top;
        top = v[SUM_W-1:POS_W-1];
        if ((&top) || !(|top)) begin
            return v[POS_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    logic [STIFF_W-1:0] stiff_reg;
    logic out_ld;
    logic en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= STIFF_RESET;
        end else if (cfg_valid) begin
            stiff_reg <= cfg_data;
        end
    end

    assign out_ld   = !m_tvalid || m_tready;
    assign en       = !v6_reg || out_ld;
    assign s_tready = en;

    // Stage 1: separation and magnitudes.
    logic [2:0][POS_W-1:0] in_a, in_b;
    front_t f1_next, f1_reg;

    assign in_a[0] = s_tdata[31:0];
    assign in_a[1] = s_tdata[63:32];
    assign in_a[2] = s_tdata[95:64];
    assign in_b[0] = s_tdata[151:120];
    assign in_b[1] = s_tdata[183:152];
    assign in_b[2] = s_tdata[215:184];

    always_comb begin
        logic [MAG_W-1:0] d;
        f1_next.pa   = in_a;
        f1_next.pb   = in_b;
        f1_next.wa   = s_tdata[119:96];
        f1_next.wb   = s_tdata[239:216];
        f1_next.rest = s_tdata[270:240];
        for (int i = 0; i < 3; i++) begin
            d = {in_b[i][POS_W-1], in_b[i]} - {in_a[i][POS_W-1], in_a[i]};
            f1_next.sgn[i] = d[MAG_W-1];
            f1_next.mag[i] = d[MAG_W-1] ? -d : d;
        end
    end

    // Stage 2: squares and stiffness products.
    root_side_t r2_next, r2_reg;
    logic [2:0][SQ_W-1:0] sq2_next, sq2_reg;

    always_comb begin
        r2_next.pa   = f1_reg.pa;
        r2_next.pb   = f1_reg.pb;
        r2_next.sgn  = f1_reg.sgn;
        r2_next.mag  = f1_reg.mag;
        r2_next.rest = f1_reg.rest;
        r2_next.pka  = KP_W'(stiff_reg) * KP_W'(f1_reg.wa);
        r2_next.pkb  = KP_W'(stiff_reg) * KP_W'(f1_reg.wb);
        r2_next.wsum = WSUM_W'(f1_reg.wa) + WSUM_W'(f1_reg.wb);
        r2_next.skip = (f1_reg.wa == '0) && (f1_reg.wb == '0);
        for (int i = 0; i < 3; i++) begin
            sq2_next[i] = SQ_W'(f1_reg.mag[i]) * SQ_W'(f1_reg.mag[i]);
        end
    end

    // Stage 3: squared length.
    root_side_t r3_next, r3_reg;
    logic [SQ_W-1:0] s3_next, s3_reg;

    always_comb begin
        s3_next      = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        r3_next      = r2_reg;
        r3_next.skip = r2_reg.skip || (s3_next == '0);
    end

    logic              sr_valid;
    logic [ROOT_W-1:0] sr_root;
    logic [$bits(root_side_t)-1:0] sr_side_bits;
    root_side_t        sr_side;

    dcp_isqrt #(
        .SIDE_W ($bits(root_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_sq     (s3_reg),
        .in_side   (r3_reg),
        .out_valid (sr_valid),
        .out_root  (sr_root),
        .out_side  (sr_side_bits)
    );

    assign sr_side = sr_side_bits;

    // Stage 4: length error and divider operands.
    div_side_t ds4_next, ds4_reg;
    logic [LANES-1:0][ND_W-1:0] num4_next, num4_reg;
    logic [LANES-1:0][DV_W-1:0] den4_next, den4_reg;

    always_comb begin
        logic [ROOT_W:0] diff;
        logic [ROOT_W:0] ndiff;
        diff  = {1'b0, sr_root} - (ROOT_W+1)'(sr_side.rest);
        ndiff = -diff;
        ds4_next.pa   = sr_side.pa;
        ds4_next.pb   = sr_side.pb;
        ds4_next.sgn  = sr_side.sgn;
        ds4_next.dneg = diff[ROOT_W];
        ds4_next.dmag = diff[ROOT_W] ? ndiff[ROOT_W-1:0] : diff[ROOT_W-1:0];
        ds4_next.skip = sr_side.skip;
        num4_next[0]  = ND_W'(sr_side.pka);
        num4_next[1]  = ND_W'(sr_side.pkb);
        den4_next[0]  = DV_W'(sr_side.wsum);
        den4_next[1]  = DV_W'(sr_side.wsum);
        for (int i = 0; i < 3; i++) begin
            num4_next[2+i] = ND_W'(sr_side.mag[i]) << FRAC_BITS;
            den4_next[2+i] = sr_root;
        end
    end

    logic                    dv_valid;
    logic [LANES-1:0][QW-1:0] dv_quo;
    logic [$bits(div_side_t)-1:0] dv_side_bits;
    div_side_t               dv_side;

    dcp_div #(
        .LANES  (LANES),
        .ND_W   (ND_W),
        .DV_W   (DV_W),
        .QW     (QW),
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (ds4_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side_bits)
    );

    assign dv_side = dv_side_bits;

    // Stage 5: correction magnitude per particle.
    logic [TP_W-1:0] tpa, tpb;
    logic [TA_W-1:0] ta5_reg, tb5_reg;
    logic [2:0][DIR_W-1:0] dir5_next, dir5_reg;
    div_side_t s5_reg;

    assign tpa = TP_W'(dv_side.dmag) * TP_W'(dv_quo[0][K_W-1:0]);
    assign tpb = TP_W'(dv_side.dmag) * TP_W'(dv_quo[1][K_W-1:0]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dir5_next[i] = dv_quo[2+i][DIR_W-1:0];
        end
    end

    // Stage 6: moves along each axis.
    logic [2:0][MV_W-1:0] ma6_next, ma6_reg, mb6_next, mb6_reg;
    div_side_t s6_reg;

    always_comb begin
        logic [MP_W-1:0] pa_m;
        logic [MP_W-1:0] pb_m;
        for (int i = 0; i < 3; i++) begin
            pa_m = MP_W'(dir5_reg[i]) * MP_W'(ta5_reg);
            pb_m = MP_W'(dir5_reg[i]) * MP_W'(tb5_reg);
            ma6_next[i] = pa_m[MP_W-1:FRAC_BITS];
            mb6_next[i] = pb_m[MP_W-1:FRAC_BITS];
        end
    end

    // Output stage: apply, saturate or pass through.
    logic [M_DATA_W-1:0] m_tdata_next, m_tdata_reg;
    logic m_tvalid_reg, m_tuser_reg;

    always_comb begin
        logic [SUM_W-1:0] ea, eb, mva, mvb, na, nb;
        logic neg;
        for (int i = 0; i < 3; i++) begin
            ea  = {{(SUM_W-POS_W){s6_reg.pa[i][POS_W-1]}}, s6_reg.pa[i]};
            eb  = {{(SUM_W-POS_W){s6_reg.pb[i][POS_W-1]}}, s6_reg.pb[i]};
            mva = {{(SUM_W-MV_W){1'b0}}, ma6_reg[i]};
            mvb = {{(SUM_W-MV_W){1'b0}}, mb6_reg[i]};
            neg = s6_reg.sgn[i] ^ s6_reg.dneg;
            na  = neg ? ea - mva : ea + mva;
            nb  = neg ? eb + mvb : eb - mvb;
            m_tdata_next[i*POS_W +: POS_W] = s6_reg.skip ? s6_reg.pa[i] : sat_pos(na);
            m_tdata_next[(3+i)*POS_W +: POS_W] = s6_reg.skip ? s6_reg.pb[i] : sat_pos(nb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sr_valid;
            v5_reg <= dv_valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg   <= f1_next;
            r2_reg   <= r2_next;
            sq2_reg  <= sq2_next;
            r3_reg   <= r3_next;
            s3_reg   <= s3_next;
            ds4_reg  <= ds4_next;
            num4_reg <= num4_next;
            den4_reg <= den4_next;
            ta5_reg  <= tpa[TP_W-1:FRAC_BITS];
            tb5_reg  <= tpb[TP_W-1:FRAC_BITS];
            dir5_reg <= dir5_next;
            s5_reg   <= dv_side;
            ma6_reg  <= ma6_next;
            mb6_reg  <= mb6_next;
            s6_reg   <= s5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ld) begin
            m_tvalid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= s6_reg.skip;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `DCP_ASSERT_IMP(a_stall_when_full, aclk, aresetn, !s_tready, v6_reg && m_tvalid && !m_tready, "input stalled while the last stage can drain")
    `DCP_ASSERT_NXT(a_last_moves_out, aclk, aresetn, v6_reg && out_ld, m_tvalid, "item in the last stage was not moved to the output")
    `DCP_ASSERT_IMP(a_gain_bound, aclk, aresetn, dv_valid && !dv_side.skip, dv_quo[0] <= K_MAX && dv_quo[1] <= K_MAX, "mass share gain above stiffness range")
    `DCP_ASSERT_IMP(a_dir_bound, aclk, aresetn, dv_valid && !dv_side.skip, dv_quo[2] <= DIR_MAX && dv_quo[3] <= DIR_MAX && dv_quo[4] <= DIR_MAX, "direction component above one")
endmodule
`default_nettype wire

/* design/dcp_isqrt.sv */
`default_nettype none
module dcp_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [dcp_pkg::SQ_W-1:0]    in_sq,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [dcp_pkg::ROOT_W-1:0]  out_root,
    output logic [SIDE_W-1:0]           out_side
);
    import dcp_pkg::*;

    localparam int N = ROOT_W;

    logic              valid_reg [N];
    logic [SQ_W-1:0]   rem_reg   [N];
    logic [ROOT_W-1:0] root_reg  [N];
    logic [SIDE_W-1:0] side_reg  [N];

    genvar s;
    for (s = 0; s < N; s++) begin : g_stage
        localparam int B = N - 1 - s;
        logic              v_in;
        logic [SQ_W-1:0]   rem_in;
        logic [SQ_W-1:0]   trial;
        logic [SQ_W-1:0]   rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic [SIDE_W-1:0] side_in;
        logic              take;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_sq;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign trial = ({{(SQ_W-ROOT_W){1'b0}}, root_in} << (B + 1))
                     | (SQ_W'(1) << (2 * B));
        assign take      = rem_in >= trial;
        assign rem_next  = take ? rem_in - trial : rem_in;
        assign root_next = take ? (root_in | (ROOT_W'(1) << B)) : root_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule
`default_nettype wire

/* design/dcp_div.sv */
`default_nettype none
module dcp_div #(
    parameter int LANES  = 1,
    parameter int ND_W   = 8,
    parameter int DV_W   = 8,
    parameter int QW     = 8,
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][ND_W-1:0]  in_num,
    input  logic [LANES-1:0][DV_W-1:0]  in_den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    out_quo,
    output logic [SIDE_W-1:0]           out_side
);
    localparam int RW = (ND_W > DV_W + QW) ? ND_W : DV_W + QW;

    logic                        valid_reg [QW];
    logic [LANES-1:0][RW-1:0]    rem_reg   [QW];
    logic [LANES-1:0][DV_W-1:0]  den_reg   [QW];
    logic [LANES-1:0][QW-1:0]    quo_reg   [QW];
    logic [SIDE_W-1:0]           side_reg  [QW];

    genvar s;
    for (s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic                        v_in;
        logic [LANES-1:0][RW-1:0]    rem_in;
        logic [LANES-1:0][RW-1:0]    rem_next;
        logic [LANES-1:0][DV_W-1:0]  den_in;
        logic [LANES-1:0][QW-1:0]    quo_in;
        logic [LANES-1:0][QW-1:0]    quo_next;
        logic [SIDE_W-1:0]           side_in;
        logic [RW-1:0]               shifted [LANES];
        logic [LANES-1:0]            take;

        if (s == 0) begin : g_first
            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    rem_in[k] = RW'(in_num[k]);
                end
            end
            assign v_in    = in_valid;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                shifted[k]  = RW'(den_in[k]) << B;
                take[k]     = rem_in[k] >= shifted[k];
                rem_next[k] = take[k] ? rem_in[k] - shifted[k] : rem_in[k];
                quo_next[k] = take[k] ? (quo_in[k] | (QW'(1) << B)) : quo_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];
endmodule
`default_nettype wire

/* dv/distance_constraint_projection_test.sv */
`default_nettype none
module distance_constraint_projection_test;
    import dcp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0][POS_W-1:0] pa;
        logic [W_W-1:0]        wa;
        logic [2:0][POS_W-1:0] pb;
        logic [W_W-1:0]        wb;
        logic [REST_W-1:0]     rest;
    } constraint_t;

    typedef struct {
        logic [2:0][POS_W-1:0] na;
        logic [2:0][POS_W-1:0] nb;
        logic                  skipped;
    } projection_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [STIFF_W-1:0] cfg_data = '0;

    constraint_t stim_q[$];
    projection_t projected_q[$];
    logic [STIFF_W-1:0] stiffness_model = STIFF_RESET;
    int errors = 0;
    int cycles = 0;
    logic s_took = 1'b0;
    int s_gap = 0;
    int m_gap = 0;
    logic idling_on = 1'b1;
    logic send_hold = 1'b0;

    distance_constraint_projection u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [S_DATA_W-1:0] pack_constraint(constraint_t c);
        return {1'b0, c.rest, c.wb, c.pb[2], c.pb[1], c.pb[0],
                c.wa, c.pa[2], c.pa[1], c.pa[0]};
    endfunction

    function automatic logic [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic projection_t project(constraint_t c, logic [STIFF_W-1:0] stiff);
        projection_t r;
        logic signed [63:0] d[3];
        logic [63:0] mag[3];
        logic [127:0] sum_sq, cand;
        logic [63:0] seg_len, dmag, ka, kb, ta, tb, dir, ma, mb;
        logic signed [63:0] diff, pa_s, pb_s;
        logic [63:0] wsum;
        logic dneg, neg;
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 64'($signed(c.pb[i])) - 64'($signed(c.pa[i]));
            mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            sum_sq = sum_sq + 128'(mag[i]) * 128'(mag[i]);
        end
        wsum = 64'(c.wa) + 64'(c.wb);
        r.na = c.pa;
        r.nb = c.pb;
        r.skipped = 1'b1;
        if (wsum == 0 || sum_sq == 0) return r;
        seg_len = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = 128'(seg_len | (64'd1 << b));
            if (cand * cand <= sum_sq) seg_len = cand[63:0];
        end
        diff = $signed(seg_len) - $signed(64'(c.rest));
        dneg = diff < 0;
        dmag = dneg ? 64'(-diff) : 64'(diff);
        ka = (64'(stiff) * 64'(c.wa)) / wsum;
        kb = (64'(stiff) * 64'(c.wb)) / wsum;
        ta = (dmag * ka) >> FB;
        tb = (dmag * kb) >> FB;
        for (int i = 0; i < 3; i++) begin
            dir = (mag[i] << FB) / seg_len;
            ma = (dir * ta) >> FB;
            mb = (dir * tb) >> FB;
            neg = (d[i] < 0) != dneg;
            pa_s = 64'($signed(c.pa[i]));
            pb_s = 64'($signed(c.pb[i]));
            r.na[i] = clamp32(neg ? pa_s - $signed(ma) : pa_s + $signed(ma));
            r.nb[i] = clamp32(neg ? pb_s + $signed(mb) : pb_s - $signed(mb));
        end
        r.skipped = 1'b0;
        return r;
    endfunction

    function automatic constraint_t random_constraint();
        constraint_t c;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            c.pa[i] = $urandom;
            c.pb[i] = $urandom;
        end
        c.wa = W_W'($urandom);
        c.wb = W_W'($urandom);
        c.rest = REST_W'($urandom);
        if (kind == 1) begin
            c.wa = '0;
            c.wb = '0;
        end else if (kind == 2) begin
            c.pb = c.pa;
        end else if (kind >= 3) begin
            for (int i = 0; i < 3; i++) begin
                c.pa[i] = $signed($urandom) >>> $urandom_range(1, 8);
                c.pb[i] = c.pa[i] + ($signed($urandom) >>> $urandom_range(4, 28));
            end
            if ($urandom_range(0, 3) == 0) c.wa = $urandom_range(0, 1) ? '0 : 24'h010000;
            if ($urandom_range(0, 3) == 0) c.wb = $urandom_range(0, 1) ? '0 : 24'h010000;
            c.rest = REST_W'($urandom >> $urandom_range(1, 24));
        end
        return c;
    endfunction

    task automatic add_constraint(logic [31:0] ax, ay, az, logic [23:0] wa,
                                  logic [31:0] bx, by, bz, logic [23:0] wb,
                                  logic [30:0] rest);
        constraint_t c;
        c.pa[0] = ax; c.pa[1] = ay; c.pa[2] = az; c.wa = wa;
        c.pb[0] = bx; c.pb[1] = by; c.pb[2] = bz; c.wb = wb;
        c.rest = rest;
        stim_q.push_back(c);
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || projected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_stiffness(logic [STIFF_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!(s_tvalid && !s_took)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    s_gap <= $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() != 0 && !send_hold) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_constraint(stim_q[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        projection_t want;
        logic [31:0] got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                projected_q.push_back(project(stim_q[0], stiffness_model));
                void'(stim_q.pop_front());
            end
            if (cfg_valid && cfg_ready) stiffness_model <= cfg_data;
            if (m_tvalid && m_tready) begin
                if (projected_q.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %h %b", $realtime, m_tdata,
                             m_tuser);
                    errors++;
                end else begin
                    want = projected_q.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        got = m_tdata[32*i +: 32];
                        if (got !== (i < 3 ? want.na[i] : want.nb[i-3])) begin
                            $display("%0t: position %0d expected %h actual %h", $realtime, i,
                                     i < 3 ? want.na[i] : want.nb[i-3], got);
                            errors++;
                        end
                    end
                    if (m_tuser[0] !== want.skipped) begin
                        $display("%0t: skipped expected %b actual %b", $realtime,
                                 want.skipped, m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        logic [STIFF_W-1:0] stiff_plan[5];
        stiff_plan[0] = '0;
        stiff_plan[1] = 17'h1ffff;
        stiff_plan[2] = 17'h08000;
        stiff_plan[3] = STIFF_W'($urandom);
        stiff_plan[4] = STIFF_RESET;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        add_constraint(0, 0, 0, 24'h010000, 32'h00010000, 0, 0, 24'h010000, 0);
        add_constraint(1, 2, 3, 0, 5, 6, 7, 0, 31'h10);
        add_constraint(32'h1234, 32'h5678, 32'h9abc, 24'hffffff,
                       32'h1234, 32'h5678, 32'h9abc, 24'hffffff, 31'h100);
        add_constraint(32'h80000000, 32'h80000000, 32'h80000000, 24'hffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'hffffff, 0);
        add_constraint(32'h7fffffff, 32'h80000000, 0, 24'hffffff,
                       32'h80000000, 32'h7fffffff, 0, 24'h000001, 31'h7fffffff);
        add_constraint(0, 0, 0, 0, 32'h00030000, 32'h00040000, 0, 24'h010000, 31'h00010000);
        add_constraint(0, 0, 0, 24'h010000, 32'h00030000, 32'h00040000, 0, 0, 31'h000a0000);
        add_constraint(32'hfff00000, 0, 32'h00100000, 24'h000001,
                       32'h00100000, 32'h00050000, 32'hfff00000, 24'hffffff, 31'h7fffffff);
        add_constraint(32'h10000000, 32'h10000000, 32'h10000000, 24'h800000,
                       32'hf0000000, 32'hf0000000, 32'hf0000000, 24'h800000, 0);
        add_constraint(0, 0, 0, 24'h010000, 0, 0, 1, 24'h010000, 0);
        add_constraint(0, 0, 0, 24'h010000, 0, 0, 32'hffffffff, 24'h010000, 31'h7fffffff);
        for (int i = 0; i < 8; i++) stim_q.push_back(random_constraint());
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_stiffness(stiff_plan[p]);
            if (p == 4) idling_on <= 1'b0;
            for (int i = 0; i < 86; i++) begin
                if (p == 2 && i == 40) begin
                    send_hold <= 1'b1;
                    @(negedge aclk);
                    while (s_tvalid || projected_q.size() != 0) @(negedge aclk);
                    send_hold <= 1'b0;
                end
                stim_q.push_back(random_constraint());
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/dcp_pkg.sv
design/dcp_isqrt.sv
design/dcp_div.sv
design/distance_constraint_projection.sv
dv/distance_constraint_projection_test.sv
